// ===== design/rational_number_alu_assert.svh =====
// ---------------------------------------------------------------------------
// Rational number ALU assertion macros
// Shared property forms for the checks at the end of the top level.
// ---------------------------------------------------------------------------
`ifndef RATIONAL_NUMBER_ALU_ASSERT_SVH
`define RATIONAL_NUMBER_ALU_ASSERT_SVH

// same-cycle implication on clk, off while rst is high
`define RNA_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rational_number_alu: assertion failed");

// next-cycle implication on clk, off while rst is high
`define RNA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rational_number_alu: assertion failed");

`endif

// ===== design/rna_pkg.sv =====
// ---------------------------------------------------------------------------
// Rational number ALU package
// Operation and status codes, command codes and controller/datapath structs.
// ---------------------------------------------------------------------------
package rna_pkg;

  localparam logic [2:0] OP_ADD = 3'd0;
  localparam logic [2:0] OP_SUB = 3'd1;
  localparam logic [2:0] OP_MUL = 3'd2;
  localparam logic [2:0] OP_DIV = 3'd3;
  localparam logic [2:0] OP_CMP = 3'd4;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_DIVZ = 2'd1;
  localparam logic [1:0] ST_OVF  = 2'd2;

  // result kinds for the output write
  localparam logic [1:0] RK_ZERO  = 2'd0;
  localparam logic [1:0] RK_DIVZ  = 2'd1;
  localparam logic [1:0] RK_CMP   = 2'd2;
  localparam logic [1:0] RK_ARITH = 2'd3;

  // datapath commands
  localparam logic [3:0] C_NONE   = 4'd0;
  localparam logic [3:0] C_LOAD   = 4'd1;
  localparam logic [3:0] C_MSTART = 4'd2;
  localparam logic [3:0] C_MSTEP  = 4'd3;
  localparam logic [3:0] C_MSTORE = 4'd4;
  localparam logic [3:0] C_COMB   = 4'd5;
  localparam logic [3:0] C_GINIT  = 4'd6;
  localparam logic [3:0] C_GSTEP  = 4'd7;
  localparam logic [3:0] C_DSTART = 4'd8;
  localparam logic [3:0] C_DSTEP  = 4'd9;
  localparam logic [3:0] C_DSTORE = 4'd10;
  localparam logic [3:0] C_WRITE  = 4'd11;

  typedef struct packed {
    logic [3:0] op;
    logic [1:0] sel;
  } cmd_t;

  typedef struct packed {
    logic mul_done;
    logic gcd_done;
    logic div_done;
    logic bad_op;
    logic zero_err;
    logic is_cmp;
    logic out_busy;
  } stat_t;

endpackage

// ===== design/rna_datapath.sv =====
// ---------------------------------------------------------------------------
// Rational number ALU datapath
// Shift-add multiplier, binary gcd, restoring divider and output register.
// ---------------------------------------------------------------------------
module rna_datapath #(
  parameter int VALUE_WIDTH = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  rna_pkg::cmd_t       cmd,
  output rna_pkg::stat_t      stat,
  input  logic [2:0]          operation,
  input  logic signed [63:0]  a_num,
  input  logic [62:0]         a_den,
  input  logic signed [63:0]  b_num,
  input  logic [62:0]         b_den,
  output logic                out_valid,
  input  logic                out_stall,
  output logic signed [63:0]  result_num,
  output logic [62:0]         result_den,
  output logic                less_than,
  output logic [1:0]          status
);
  import rna_pkg::*;

  localparam int SH = 64 - VALUE_WIDTH;
  localparam logic [62:0] DMASK = 63'((64'd1 << (VALUE_WIDTH - 1)) - 64'd1);
  localparam logic [127:0] NUM_MIN = 128'd1 << (VALUE_WIDTH - 1);

  localparam logic [2:0] PH_BOTH = 3'd0;
  localparam logic [2:0] PH_A    = 3'd1;
  localparam logic [2:0] PH_LOOP = 3'd2;
  localparam logic [2:0] PH_SHL  = 3'd3;
  localparam logic [2:0] PH_DONE = 3'd4;

  logic [2:0]         op_r;
  logic signed [63:0] an_r, bn_r;
  logic [62:0]        ad_r, bd_r;
  logic signed [63:0] an_sx, bn_sx;
  logic               aneg, bneg;
  logic [63:0]        amag, bmag;

  logic [127:0] macc, mca, p0, p1, p2;
  logic [63:0]  mpl;
  logic [7:0]   cnt;
  logic [127:0] ma;
  logic [63:0]  mb;

  logic [127:0] nm, dn;
  logic         nneg;
  logic         lt;

  logic [127:0] ga, gb;
  logic [7:0]   gk;
  logic [2:0]   gph;

  logic [127:0] dq;
  logic [128:0] dr;
  logic [128:0] trial;

  // combine
  logic         p0nz, p1nz, xneg, yneg, gt, eq;
  logic [127:0] sum, d01, d10;
  logic         c_lt, c_neg;
  logic [127:0] c_mag;

  // result
  logic         fits;
  logic [63:0]  nval;
  logic signed [63:0] nsx;

  assign an_sx = (a_num <<< SH) >>> SH;
  assign bn_sx = (b_num <<< SH) >>> SH;
  assign aneg  = an_r[63];
  assign bneg  = bn_r[63];
  assign amag  = aneg ? 64'(-an_r) : an_r;
  assign bmag  = bneg ? 64'(-bn_r) : bn_r;

  always_comb begin
    unique case (cmd.sel)
      2'd0: begin
        ma = {64'd0, amag};
        mb = (op_r == OP_MUL) ? bmag : {1'b0, bd_r};
      end
      2'd1: begin
        ma = {64'd0, bmag};
        mb = {1'b0, ad_r};
      end
      default: begin
        ma = {65'd0, ad_r};
        mb = (op_r == OP_DIV) ? bmag : {1'b0, bd_r};
      end
    endcase
  end

  always_comb begin
    p0nz  = p0 != 128'd0;
    p1nz  = p1 != 128'd0;
    xneg  = aneg && p0nz;
    yneg  = (bneg ^ (op_r == OP_SUB)) && p1nz;
    gt    = p0 > p1;
    eq    = p0 == p1;
    sum   = p0 + p1;
    d01   = p0 - p1;
    d10   = p1 - p0;
    if (xneg != yneg) c_lt = xneg;
    else if (xneg)    c_lt = gt;
    else              c_lt = !gt && !eq;
    if (op_r == OP_MUL || op_r == OP_DIV) begin
      c_neg = (aneg ^ bneg) && p0nz;
      c_mag = p0;
    end else if (xneg == yneg) begin
      c_neg = xneg;
      c_mag = sum;
    end else if (eq) begin
      c_neg = 1'b0;
      c_mag = 128'd0;
    end else if (gt) begin
      c_neg = xneg;
      c_mag = d01;
    end else begin
      c_neg = yneg;
      c_mag = d10;
    end
  end

  assign trial = {dr[127:0], dq[127]};

  assign fits = ((dn >> (VALUE_WIDTH - 1)) == 128'd0) &&
                (((nm >> (VALUE_WIDTH - 1)) == 128'd0) || (nneg && nm == NUM_MIN));
  assign nval = nneg ? 64'(-nm[63:0]) : nm[63:0];
  assign nsx  = $signed(nval << SH) >>> SH;

  always_ff @(posedge clk) begin
    case (cmd.op)
      C_LOAD: begin
        op_r <= operation;
        an_r <= an_sx;
        bn_r <= bn_sx;
        ad_r <= a_den & DMASK;
        bd_r <= b_den & DMASK;
      end
      C_MSTART: begin
        macc <= 128'd0;
        mca  <= ma;
        mpl  <= mb;
        cnt  <= 8'd0;
      end
      C_MSTEP: begin
        if (mpl[0]) macc <= macc + mca;
        mca <= mca << 1;
        mpl <= mpl >> 1;
        cnt <= cnt + 8'd1;
      end
      C_MSTORE: begin
        case (cmd.sel)
          2'd0:    p0 <= macc;
          2'd1:    p1 <= macc;
          default: p2 <= macc;
        endcase
      end
      C_COMB: begin
        nm   <= c_mag;
        nneg <= c_neg;
        dn   <= p2;
        lt   <= c_lt;
      end
      C_GINIT: begin
        if (nm == 128'd0) begin
          ga <= dn;
          gb <= 128'd0;
        end else begin
          ga <= nm;
          gb <= dn;
        end
        gk <= 8'd0;
      end
      C_GSTEP: begin
        case (gph)
          PH_BOTH: if (!ga[0] && !gb[0]) begin
            ga <= ga >> 1;
            gb <= gb >> 1;
            gk <= gk + 8'd1;
          end
          PH_A: if (!ga[0]) ga <= ga >> 1;
          PH_LOOP: begin
            if (gb != 128'd0) begin
              if (!gb[0]) begin
                gb <= gb >> 1;
              end else if (ga > gb) begin
                ga <= gb;
                gb <= ga - gb;
              end else begin
                gb <= gb - ga;
              end
            end
          end
          PH_SHL: if (gk != 8'd0) begin
            ga <= ga << 1;
            gk <= gk - 8'd1;
          end
          default: ;
        endcase
      end
      C_DSTART: begin
        dq  <= cmd.sel[0] ? dn : nm;
        dr  <= 129'd0;
        cnt <= 8'd0;
      end
      C_DSTEP: begin
        if (trial >= {1'b0, ga}) begin
          dr <= trial - {1'b0, ga};
          dq <= {dq[126:0], 1'b1};
        end else begin
          dr <= trial;
          dq <= {dq[126:0], 1'b0};
        end
        cnt <= cnt + 8'd1;
      end
      C_DSTORE: begin
        if (cmd.sel[0]) dn <= dq;
        else            nm <= dq;
      end
      C_WRITE: begin
        result_num <= 64'sd0;
        result_den <= 63'd0;
        less_than  <= 1'b0;
        status     <= ST_OK;
        case (cmd.sel)
          RK_DIVZ: status <= ST_DIVZ;
          RK_CMP:  less_than <= lt;
          RK_ARITH: begin
            result_num <= nsx;
            if (fits) result_den <= dn[62:0];
            else      status <= ST_OVF;
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  // gcd phase sequencing
  always_ff @(posedge clk) begin
    if (rst) begin
      gph <= PH_DONE;
    end else if (cmd.op == C_GINIT) begin
      gph <= PH_BOTH;
    end else if (cmd.op == C_GSTEP) begin
      case (gph)
        PH_BOTH: if (ga[0] || gb[0]) gph <= PH_A;
        PH_A:    if (ga[0]) gph <= PH_LOOP;
        PH_LOOP: if (gb == 128'd0) gph <= PH_SHL;
        PH_SHL:  if (gk == 8'd0) gph <= PH_DONE;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.op == C_WRITE) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  assign stat.mul_done = cnt == 8'd64;
  assign stat.div_done = cnt == 8'd128;
  assign stat.gcd_done = gph == PH_DONE;
  assign stat.bad_op   = op_r > OP_CMP;
  assign stat.zero_err = ad_r == 63'd0 || bd_r == 63'd0 ||
                         (op_r == OP_DIV && bmag == 64'd0);
  assign stat.is_cmp   = op_r == OP_CMP;
  assign stat.out_busy = out_valid && out_stall;

endmodule

// ===== design/rna_ctrl.sv =====
// ---------------------------------------------------------------------------
// Rational number ALU controller
// Sequences products, combine, gcd, two divisions and the output write.
// ---------------------------------------------------------------------------
module rna_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  rna_pkg::stat_t  stat,
  output rna_pkg::cmd_t   cmd
);
  import rna_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_CHECK  = 4'd1;
  localparam logic [3:0] S_MSTART = 4'd2;
  localparam logic [3:0] S_MRUN   = 4'd3;
  localparam logic [3:0] S_COMB   = 4'd4;
  localparam logic [3:0] S_GINIT  = 4'd5;
  localparam logic [3:0] S_GRUN   = 4'd6;
  localparam logic [3:0] S_DSTART = 4'd7;
  localparam logic [3:0] S_DRUN   = 4'd8;
  localparam logic [3:0] S_OUT    = 4'd9;

  logic [3:0] state, state_next;
  logic [1:0] idx, idx_next;
  logic [1:0] kind, kind_next;

  assign in_stall = state != S_IDLE;

  always_comb begin
    state_next = state;
    idx_next   = idx;
    kind_next  = kind;
    cmd.op     = C_NONE;
    cmd.sel    = idx;
    unique case (state)
      S_IDLE: if (in_valid) begin
        cmd.op     = C_LOAD;
        state_next = S_CHECK;
      end
      S_CHECK: begin
        idx_next = 2'd0;
        if (stat.bad_op) begin
          kind_next  = RK_ZERO;
          state_next = S_OUT;
        end else if (stat.zero_err) begin
          kind_next  = RK_DIVZ;
          state_next = S_OUT;
        end else begin
          state_next = S_MSTART;
        end
      end
      S_MSTART: begin
        cmd.op     = C_MSTART;
        state_next = S_MRUN;
      end
      S_MRUN: begin
        if (stat.mul_done) begin
          cmd.op = C_MSTORE;
          if (idx == 2'd2) begin
            state_next = S_COMB;
          end else begin
            idx_next   = idx + 2'd1;
            state_next = S_MSTART;
          end
        end else begin
          cmd.op = C_MSTEP;
        end
      end
      S_COMB: begin
        cmd.op = C_COMB;
        if (stat.is_cmp) begin
          kind_next  = RK_CMP;
          state_next = S_OUT;
        end else begin
          state_next = S_GINIT;
        end
      end
      S_GINIT: begin
        cmd.op     = C_GINIT;
        state_next = S_GRUN;
      end
      S_GRUN: begin
        if (stat.gcd_done) begin
          idx_next   = 2'd0;
          state_next = S_DSTART;
        end else begin
          cmd.op = C_GSTEP;
        end
      end
      S_DSTART: begin
        cmd.op     = C_DSTART;
        state_next = S_DRUN;
      end
      S_DRUN: begin
        if (stat.div_done) begin
          cmd.op = C_DSTORE;
          if (idx == 2'd1) begin
            kind_next  = RK_ARITH;
            state_next = S_OUT;
          end else begin
            idx_next   = 2'd1;
            state_next = S_DSTART;
          end
        end else begin
          cmd.op = C_DSTEP;
        end
      end
      S_OUT: if (!stat.out_busy) begin
        cmd.op     = C_WRITE;
        cmd.sel    = kind;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      idx   <= 2'd0;
      kind  <= RK_ZERO;
    end else begin
      state <= state_next;
      idx   <= idx_next;
      kind  <= kind_next;
    end
  end

endmodule

// ===== design/rational_number_alu.sv =====
// ---------------------------------------------------------------------------
// Rational number ALU
// Add, subtract, multiply, divide or less-than compare of two fractions,
// reduced to lowest terms by a binary gcd with a positive denominator.
// ---------------------------------------------------------------------------
//
//  channel  | handshake            | payload
//  ---------+----------------------+-------------------------------------------
//  request  | in_valid / in_stall  | operation, a_num, a_den, b_num, b_den
//  result   | out_valid / out_stall| result_num, result_den, less_than, status
//
//  Steps: three 64-step shift-add products, a binary gcd of one step per
//  cycle on 128-bit values and two 128-step restoring divisions per
//  request. Errors and unused codes go straight to the output write;
//  compare skips the gcd and the divisions.
//  Reset: rst clears the controller and output valid; no clearing pass.
//  Stalls: a result sits in the output register while out_stall is high; the
//  next request is taken and worked meanwhile, holding only at its write.
//
module rational_number_alu #(
  parameter int VALUE_WIDTH = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         operation,
  input  logic signed [63:0] a_num,
  input  logic [62:0]        a_den,
  input  logic signed [63:0] b_num,
  input  logic [62:0]        b_den,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [63:0] result_num,
  output logic [62:0]        result_den,
  output logic               less_than,
  output logic [1:0]         status
);
  import rna_pkg::*;

  `include "rational_number_alu_assert.svh"

  cmd_t  cmd;
  stat_t stat;

  // sequencer: one request at a time through the shared units
  rna_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // arithmetic units and the output register
  rna_datapath #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .operation  (operation),
    .a_num      (a_num),
    .a_den      (a_den),
    .b_num      (b_num),
    .b_den      (b_den),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .result_num (result_num),
    .result_den (result_den),
    .less_than  (less_than),
    .status     (status)
  );

  // a taken request keeps the input closed while it is worked
  `RNA_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)
  // error results carry no fraction
  `RNA_ASSERT_IMPL(a_err_no_den, out_valid && status != ST_OK, result_den == 63'd0)
  // compare results carry no fraction and no error
  `RNA_ASSERT_IMPL(a_cmp_clean, out_valid && less_than,
                   result_den == 63'd0 && result_num == 64'sd0 && status == ST_OK)
  // a result write only happens when the output register is free
  `RNA_ASSERT_IMPL(a_no_overwrite, cmd.op == C_WRITE, !(out_valid && out_stall))

endmodule

// ===== sim/tb.sv =====
// ---------------------------------------------------------------------------
// Rational number ALU testbench
// Drives requests with random gaps, predicts each result from an exact
// 130-bit signed model of fraction arithmetic and checks results in order.
// ---------------------------------------------------------------------------
module tb;
  import rna_pkg::*;

  localparam int VW = 64;
  localparam int WATCHDOG_LIMIT = 200000;
  localparam logic [2:0] OP_RSVD = 3'd5;
  localparam logic [2:0] OP_BAD = 3'd7;

  typedef struct packed {
    logic signed [63:0] num;
    logic [62:0]        den;
    logic               lt;
    logic [1:0]         st;
  } frac_result_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [2:0]         operation = '0;
  logic signed [63:0] a_num = '0;
  logic [62:0]        a_den = '0;
  logic signed [63:0] b_num = '0;
  logic [62:0]        b_den = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [63:0] result_num;
  logic [62:0]        result_den;
  logic               less_than;
  logic [1:0]         status;

  frac_result_t expected_q[$];
  int  mismatches = 0;
  int  idle_cycles = 0;
  bit  random_stall = 1'b0;

  rational_number_alu #(.VALUE_WIDTH(VW)) uut (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // mostly short gaps, now and then a long one
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 4);
    return $urandom_range(20, 300);
  endfunction

  // unsigned gcd on 128-bit magnitudes (Euclid)
  function automatic logic [127:0] gcd128(logic [127:0] x, logic [127:0] y);
    logic [127:0] t;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    return x;
  endfunction

  function automatic frac_result_t predict_fraction(logic [2:0] op, logic [63:0] an,
      logic [62:0] ad, logic [63:0] bn, logic [62:0] bd);
    frac_result_t r;
    logic signed [129:0] y, nm, dn;
    logic [127:0] nmag, dmag, g;
    logic neg;
    r = '0;
    if (op > OP_CMP) return r;
    if (ad == 0 || bd == 0 || (op == OP_DIV && bn == 0)) begin
      r.st = ST_DIVZ;
      return r;
    end
    case (op)
      OP_CMP: begin
        // a < b  <=>  an*bd < bn*ad
        r.lt = ($signed(an) * $signed({67'd0, bd})) < ($signed(bn) * $signed({67'd0, ad}));
        return r;
      end
      OP_MUL: begin
        nm = $signed(an) * $signed(bn);
        dn = $signed({67'd0, ad}) * $signed({67'd0, bd});
      end
      OP_DIV: begin
        nm = $signed(an) * $signed({67'd0, bd});
        dn = $signed({67'd0, ad}) * $signed(bn);
        if (dn < 0) begin
          nm = -nm;
          dn = -dn;
        end
      end
      default: begin
        nm = $signed(an) * $signed({67'd0, bd});
        y = $signed(bn) * $signed({67'd0, ad});
        nm = (op == OP_SUB) ? nm - y : nm + y;
        dn = $signed({67'd0, ad}) * $signed({67'd0, bd});
      end
    endcase
    neg = nm < 0;
    nmag = 128'(neg ? -nm : nm);
    dmag = 128'(dn);
    g = gcd128(nmag, dmag);
    nmag = nmag / g;
    dmag = dmag / g;
    r.num = neg ? -nmag[63:0] : nmag[63:0];
    if (dmag < 128'h8000_0000_0000_0000 && nmag[127:64] == 0 &&
        (neg ? nmag[63:0] <= 64'h8000_0000_0000_0000 : !nmag[63])) begin
      r.den = dmag[62:0];
    end else begin
      r.st = ST_OVF;
    end
    return r;
  endfunction

  // valid goes low between requests, for a random gap before each
  task automatic send_request(logic [2:0] op, logic [63:0] an, logic [62:0] ad,
      logic [63:0] bn, logic [62:0] bd);
    int g;
    g = gap_len();
    repeat (g + 1) @(negedge clk);
    operation <= op;
    a_num <= an;
    a_den <= ad;
    b_num <= bn;
    b_den <= bd;
    in_valid <= 1'b1;
    expected_q.push_back(predict_fraction(op, an, ad, bn, bd));
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // wide, narrow or tiny values so results reduce and sometimes overflow
  function automatic logic [63:0] rand_num();
    case ($urandom_range(0, 3))
      0: return rand64();
      1: return 64'($signed($urandom_range(0, 40)) - 20);
      2: return {{32{$urandom_range(0, 1) == 1}}, $urandom()};
      default: return 64'($signed($urandom_range(0, 2000)) - 1000) * 64'(1 << $urandom_range(0, 20));
    endcase
  endfunction

  function automatic logic [62:0] rand_den();
    logic [62:0] d;
    case ($urandom_range(0, 3))
      0: d = 63'(rand64());
      1: d = 63'($urandom_range(1, 30));
      2: d = 63'($urandom());
      default: d = 63'($urandom_range(1, 1000)) << $urandom_range(0, 20);
    endcase
    return (d == 0) ? 63'd1 : d;
  endfunction

  task automatic test_directed();
    localparam logic [63:0] NMAX = 64'h7fff_ffff_ffff_ffff;
    localparam logic [63:0] NMIN = 64'h8000_0000_0000_0000;
    localparam logic [62:0] DMAX = '1;
    send_request(OP_ADD, 1, 2, 1, 3);
    send_request(OP_SUB, 1, 2, 1, 2);                  // zero gives 0/1
    send_request(OP_MUL, -2, 3, 3, 4);                 // sign on numerator
    send_request(OP_DIV, 3, 4, -9, 8);
    send_request(OP_CMP, -1, 3, -1, 2);
    send_request(OP_CMP, 1, 2, 1, 2);
    send_request(OP_DIV, 5, 7, 0, 3);                  // divide by zero
    send_request(OP_ADD, 1, 0, 1, 1);                  // zero denominator
    send_request(OP_CMP, 1, 1, 1, 0);
    send_request(OP_RSVD, 1, 1, 1, 1);                 // unused codes
    send_request(OP_BAD, NMAX, DMAX, NMIN, DMAX);
    send_request(OP_ADD, NMAX, 1, NMAX, 1);            // overflow
    send_request(OP_MUL, NMIN, 1, -1, 1);
    send_request(OP_MUL, NMIN, 1, 1, 1);
    send_request(OP_SUB, NMIN, DMAX, NMAX, DMAX);
    send_request(OP_DIV, NMIN, DMAX, NMIN, DMAX);
    send_request(OP_CMP, NMIN, DMAX, NMAX, DMAX);
    send_request(OP_CMP, NMAX, 1, NMIN, 1);
    send_request(OP_MUL, NMAX, DMAX, NMAX, DMAX);
    send_request(OP_DIV, 1, DMAX, -1, DMAX);
    send_request(OP_ADD, -1, DMAX, 1, 1);
    send_request(OP_ADD, 0, 5, 0, 7);
  endtask

  task automatic test_random(int n);
    logic [2:0] op;
    logic [63:0] an, bn;
    logic [62:0] ad, bd;
    for (int i = 0; i < n; i++) begin
      op = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7))
                                        : 3'($urandom_range(0, 4));
      an = rand_num();
      bn = ($urandom_range(0, 29) == 0) ? 64'd0 : rand_num();
      ad = ($urandom_range(0, 49) == 0) ? 63'd0 : rand_den();
      bd = ($urandom_range(0, 49) == 0) ? 63'd0 : rand_den();
      send_request(op, an, ad, bn, bd);
    end
  endtask

  // sender holds off until every result is back
  task automatic test_drain_pause();
    wait (expected_q.size() == 0);
    send_request(OP_MUL, 6, 35, 14, 9);
  endtask

  // receiver stall: random gaps, with runs of no stall
  initial begin
    int sg;
    forever begin
      @(negedge clk);
      if (random_stall && $urandom_range(0, 3) == 0) begin
        sg = gap_len();
        if (sg > 0) begin
          out_stall <= 1'b1;
          repeat (sg) @(negedge clk);
        end
      end
      out_stall <= 1'b0;
      repeat ($urandom_range(0, 10)) @(negedge clk);
    end
  end

  // result checker
  always @(posedge clk) begin
    frac_result_t e;
    if (!rst && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result num=%0d", result_num);
      end else begin
        e = expected_q.pop_front();
        if (result_num !== e.num || result_den !== e.den || less_than !== e.lt ||
            status !== e.st) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp %0d/%0d lt=%0b st=%0d, got %0d/%0d lt=%0b st=%0d",
                     e.num, e.den, e.lt, e.st, result_num, result_den, less_than, status);
        end
      end
    end
  end

  // watchdog on cycles with no handshake
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    random_stall = 1'b1;
    test_random(360);
    test_drain_pause();
    test_random(370);
    wait (expected_q.size() == 0);
    repeat (1100) @(posedge clk);
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
